// ----- sv/dht_pkg.sv -----
// dht_pkg: shared constants, op and status codes and the controller command struct
// for the descriptor handle table; no dependencies
package dht_pkg;

    // fixed port field widths
    localparam int OP_W     = 3;
    localparam int SLOT_W   = 8;
    localparam int HANDLE_W = 32;
    localparam int STATUS_W = 2;
    localparam int RSLOT_W  = 6;

    // parameter defaults
    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_HANDLE_BITS = 32;

    // request op codes
    localparam logic [OP_W-1:0] OP_OPEN    = 3'd0;
    localparam logic [OP_W-1:0] OP_OPEN_AT = 3'd1;
    localparam logic [OP_W-1:0] OP_CLOSE   = 3'd2;
    localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd3;
    localparam logic [OP_W-1:0] OP_DUP     = 3'd4;
    localparam logic [OP_W-1:0] OP_DUP_TO  = 3'd5;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVAL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADF  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic load;   // capture request, read table, first encode level
        logic exec;   // decide, update table, load result register
    } t_cmd;

endpackage

// ----- sv/dht_ctrl.sv -----
// dht_ctrl: request sequencer and result valid flag for the descriptor handle table
// depends on dht_pkg (t_cmd)
module dht_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    output dht_pkg::t_cmd  o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    // result register is free when empty or being taken this cycle
    assign o_cmd.load = (r_state == S_IDLE) && i_valid;
    assign o_cmd.exec = (r_state == S_EXEC) && (!r_out_valid || i_ready);
    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (!r_out_valid || i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
            if (o_cmd.exec) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- sv/dht_datapath.sv -----
// dht_datapath: handle memory, slot used bits, two level lowest free encoder,
// request decode and result register; depends on dht_pkg
module dht_datapath #(
    parameter int TABLE_DEPTH = dht_pkg::DEF_TABLE_DEPTH,
    parameter int HANDLE_BITS = dht_pkg::DEF_HANDLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dht_pkg::t_cmd                 i_cmd,
    input  logic [dht_pkg::OP_W-1:0]      i_op,
    input  logic [dht_pkg::SLOT_W-1:0]    i_slot,
    input  logic [dht_pkg::SLOT_W-1:0]    i_target_slot,
    input  logic [dht_pkg::HANDLE_W-1:0]  i_object_handle,
    output logic [dht_pkg::STATUS_W-1:0]  o_status,
    output logic [dht_pkg::RSLOT_W-1:0]   o_result_slot,
    output logic [dht_pkg::HANDLE_W-1:0]  o_handle_out,
    output logic                          o_released_valid,
    output logic [dht_pkg::HANDLE_W-1:0]  o_released_handle
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int GRP_N = (TABLE_DEPTH + 7) / 8;
    localparam int GRP_W = (GRP_N > 1) ? $clog2(GRP_N) : 1;
    localparam int FREE_W = GRP_W + 3;

    // table storage
    logic [HANDLE_BITS-1:0] mem [0:TABLE_DEPTH-1];
    logic [TABLE_DEPTH-1:0] r_used;

    // captured request and registered reads
    logic [dht_pkg::OP_W-1:0]     r_op;
    logic [dht_pkg::SLOT_W-1:0]   r_slot;
    logic [dht_pkg::SLOT_W-1:0]   r_target;
    logic [HANDLE_BITS-1:0]       r_handle;
    logic [HANDLE_BITS-1:0]       r_rd_a;
    logic [HANDLE_BITS-1:0]       r_rd_b;

    // first encoder level, one entry per group of eight slots
    logic [GRP_N-1:0] r_grp_free;
    logic [2:0]       r_grp_low [GRP_N];
    logic [GRP_N*8-1:0] used_pad;
    logic [GRP_N-1:0]   grp_free;
    logic [2:0]         grp_low [GRP_N];

    // result register
    logic [dht_pkg::STATUS_W-1:0] r_status;
    logic [dht_pkg::RSLOT_W-1:0]  r_result_slot;
    logic [dht_pkg::HANDLE_W-1:0] r_handle_out;
    logic                         r_released_valid;
    logic [dht_pkg::HANDLE_W-1:0] r_released_handle;

    logic [dht_pkg::SLOT_W-1:0] rd_b_slot;

    // slots past the depth count as used
    always_comb begin
        used_pad = '1;
        used_pad[TABLE_DEPTH-1:0] = r_used;
        for (int g = 0; g < GRP_N; g++) begin
            grp_free[g] = ~&used_pad[g*8 +: 8];
            grp_low[g]  = 3'd0;
            for (int b = 7; b >= 0; b--) begin
                if (!used_pad[g*8 + b]) begin
                    grp_low[g] = 3'(b);
                end
            end
        end
    end

    // port b reads the slot that a placement may overwrite
    assign rd_b_slot = (i_op == dht_pkg::OP_DUP_TO) ? i_target_slot : i_slot;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_op;
            r_slot     <= i_slot;
            r_target   <= i_target_slot;
            r_handle   <= HANDLE_BITS'(i_object_handle);
            r_rd_a     <= mem[i_slot[IDX_W-1:0]];
            r_rd_b     <= mem[rd_b_slot[IDX_W-1:0]];
            r_grp_free <= grp_free;
            r_grp_low  <= grp_low;
        end
    end

    // second encoder level and request decode
    logic              free_ok;
    logic [FREE_W-1:0] free_full;
    logic [IDX_W-1:0]  free_idx;
    logic [IDX_W-1:0]  idx_s;
    logic [IDX_W-1:0]  idx_t;
    logic              s_in;
    logic              t_in;
    logic              held_s;

    logic [dht_pkg::STATUS_W-1:0] n_status;
    logic [dht_pkg::SLOT_W-1:0]   n_rs;
    logic [HANDLE_BITS-1:0]       n_ho;
    logic                         n_rv;
    logic [HANDLE_BITS-1:0]       n_rh;
    logic                         wr_en;
    logic [IDX_W-1:0]             wr_idx;
    logic [HANDLE_BITS-1:0]       wr_data;
    logic                         clr_en;

    always_comb begin
        free_ok   = |r_grp_free;
        free_full = '0;
        for (int g = GRP_N - 1; g >= 0; g--) begin
            if (r_grp_free[g]) begin
                free_full = {GRP_W'(g), r_grp_low[g]};
            end
        end
        free_idx = free_full[IDX_W-1:0];

        idx_s  = r_slot[IDX_W-1:0];
        idx_t  = r_target[IDX_W-1:0];
        s_in   = {1'b0, r_slot} < 9'(TABLE_DEPTH);
        t_in   = {1'b0, r_target} < 9'(TABLE_DEPTH);
        held_s = s_in && r_used[idx_s];

        n_status = dht_pkg::ST_OK;
        n_rs     = '0;
        n_ho     = '0;
        n_rv     = 1'b0;
        n_rh     = '0;
        wr_en    = 1'b0;
        wr_idx   = idx_s;
        wr_data  = r_handle;
        clr_en   = 1'b0;

        unique case (r_op)
            dht_pkg::OP_OPEN: begin
                if (!free_ok) begin
                    n_status = dht_pkg::ST_FULL;
                end else begin
                    wr_en  = 1'b1;
                    wr_idx = free_idx;
                    n_rs   = dht_pkg::SLOT_W'(free_idx);
                end
            end
            dht_pkg::OP_OPEN_AT: begin
                if (!s_in) begin
                    n_status = dht_pkg::ST_INVAL;
                end else begin
                    n_rv  = r_used[idx_s];
                    n_rh  = r_used[idx_s] ? r_rd_b : '0;
                    wr_en = 1'b1;
                    n_rs  = r_slot;
                end
            end
            dht_pkg::OP_CLOSE: begin
                if (!held_s) begin
                    n_status = dht_pkg::ST_BADF;
                end else begin
                    n_rv   = 1'b1;
                    n_rh   = r_rd_a;
                    clr_en = 1'b1;
                    n_rs   = r_slot;
                end
            end
            dht_pkg::OP_LOOKUP: begin
                if (!held_s) begin
                    n_status = dht_pkg::ST_BADF;
                end else begin
                    n_ho = r_rd_a;
                    n_rs = r_slot;
                end
            end
            dht_pkg::OP_DUP: begin
                if (!held_s) begin
                    n_status = dht_pkg::ST_BADF;
                end else if (!free_ok) begin
                    n_status = dht_pkg::ST_FULL;
                end else begin
                    n_ho    = r_rd_a;
                    wr_en   = 1'b1;
                    wr_idx  = free_idx;
                    wr_data = r_rd_a;
                    n_rs    = dht_pkg::SLOT_W'(free_idx);
                end
            end
            dht_pkg::OP_DUP_TO: begin
                if (!held_s || !t_in) begin
                    n_status = dht_pkg::ST_BADF;
                end else begin
                    n_ho = r_rd_a;
                    n_rs = r_target;
                    // copy onto itself changes nothing
                    if (r_target != r_slot) begin
                        n_rv    = r_used[idx_t];
                        n_rh    = r_used[idx_t] ? r_rd_b : '0;
                        wr_en   = 1'b1;
                        wr_idx  = idx_t;
                        wr_data = r_rd_a;
                    end
                end
            end
            default: begin
                n_status = dht_pkg::ST_INVAL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.exec) begin
            if (wr_en) begin
                r_used[wr_idx] <= 1'b1;
            end else if (clr_en) begin
                r_used[idx_s] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status          <= n_status;
            r_result_slot     <= n_rs[dht_pkg::RSLOT_W-1:0];
            r_handle_out      <= dht_pkg::HANDLE_W'(n_ho);
            r_released_valid  <= n_rv;
            r_released_handle <= dht_pkg::HANDLE_W'(n_rh);
        end
    end

    assign o_status          = r_status;
    assign o_result_slot     = r_result_slot;
    assign o_handle_out      = r_handle_out;
    assign o_released_valid  = r_released_valid;
    assign o_released_handle = r_released_handle;

endmodule

// ----- sv/descriptor_handle_table_core.sv -----
// descriptor_handle_table_core: top level of the descriptor handle table
// depends on dht_pkg, dht_ctrl and dht_datapath
//
// usage
// - request channel: i_valid / o_ready with i_op, i_slot, i_target_slot and
//   i_object_handle; an item is taken on a clock edge with both high
// - result channel: o_valid / i_ready with o_status, o_result_slot,
//   o_handle_out, o_released_valid and o_released_handle; exactly one result
//   item for every request item, in order
// - timing: the accept edge reads both handle memory ports and the first level
//   of the lowest free encoder; the decide edge then decides the op, writes the table
//   and loads the result register, and o_valid rises at that decide edge
// - request pacing: a new item is taken only after the last one is decided, set by
//   the read then write sequence on the handle memory; o_ready rises at the decide edge,
//   so the next item can be taken on the edge after it
// - stalls: the next request is taken while a result still waits; its decide
//   step then holds, with o_ready low, until the waiting result is taken
// - reset (i_rst_n low, synchronous) marks every slot free and empties the
//   result register; handle contents are not cleared, a free slot is never read
// - a released handle (close, open_at or dup_to over a held slot) is reported
//   on o_released_valid / o_released_handle so software can drop it
// - TABLE_DEPTH sets the slot count (2 to 64, bounded by the 6-bit o_result_slot), HANDLE_BITS the stored width
module descriptor_handle_table_core #(
    parameter int TABLE_DEPTH = dht_pkg::DEF_TABLE_DEPTH,
    parameter int HANDLE_BITS = dht_pkg::DEF_HANDLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [dht_pkg::OP_W-1:0]      i_op,
    input  logic [dht_pkg::SLOT_W-1:0]    i_slot,
    input  logic [dht_pkg::SLOT_W-1:0]    i_target_slot,
    input  logic [dht_pkg::HANDLE_W-1:0]  i_object_handle,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [dht_pkg::STATUS_W-1:0]  o_status,
    output logic [dht_pkg::RSLOT_W-1:0]   o_result_slot,
    output logic [dht_pkg::HANDLE_W-1:0]  o_handle_out,
    output logic                          o_released_valid,
    output logic [dht_pkg::HANDLE_W-1:0]  o_released_handle
);

    dht_pkg::t_cmd cmd;

    // sequencer: idle / decide, plus result valid flag
    dht_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    // table, encoder and result register
    dht_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_op              (i_op),
        .i_slot            (i_slot),
        .i_target_slot     (i_target_slot),
        .i_object_handle   (i_object_handle),
        .o_status          (o_status),
        .o_result_slot     (o_result_slot),
        .o_handle_out      (o_handle_out),
        .o_released_valid  (o_released_valid),
        .o_released_handle (o_released_handle)
    );

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// tb: self-checking bench for descriptor_handle_table_core, request and result
// channels driven and checked against an in-bench shadow of the slot table
// depends on dht_pkg and descriptor_handle_table_core
module tb;

    localparam int TABLE_DEPTH = dht_pkg::DEF_TABLE_DEPTH;
    localparam int CYCLE_LIMIT = 200000;
    // results taken before the receiver goes quiet for a long stretch
    localparam int LONG_HOLD_AT  = 150;
    localparam int LONG_HOLD_CYC = 80;
    localparam int RANDOM_ITEMS  = 600;

    // op codes the block does not know
    localparam logic [dht_pkg::OP_W-1:0] OP_UNDEF_A = 3'd6;
    localparam logic [dht_pkg::OP_W-1:0] OP_UNDEF_B = 3'd7;

    typedef struct {
        logic [dht_pkg::OP_W-1:0]     op;
        logic [dht_pkg::SLOT_W-1:0]   slot;
        logic [dht_pkg::SLOT_W-1:0]   tgt;
        logic [dht_pkg::HANDLE_W-1:0] handle;
        int                           gap_cyc;   // idle cycles before this item is offered
        bit                           drain;     // hold until all earlier results are back
    } t_req;

    typedef struct {
        logic [dht_pkg::STATUS_W-1:0] status;
        logic [dht_pkg::RSLOT_W-1:0]  rslot;
        logic [dht_pkg::HANDLE_W-1:0] hout;
        logic                         rel_v;
        logic [dht_pkg::HANDLE_W-1:0] rel_h;
    } t_res;

    // clock, reset and block ports
    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    logic [dht_pkg::OP_W-1:0]      i_op = '0;
    logic [dht_pkg::SLOT_W-1:0]    i_slot = '0;
    logic [dht_pkg::SLOT_W-1:0]    i_target_slot = '0;
    logic [dht_pkg::HANDLE_W-1:0]  i_object_handle = '0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic [dht_pkg::STATUS_W-1:0]  o_status;
    logic [dht_pkg::RSLOT_W-1:0]   o_result_slot;
    logic [dht_pkg::HANDLE_W-1:0]  o_handle_out;
    logic                          o_released_valid;
    logic [dht_pkg::HANDLE_W-1:0]  o_released_handle;

    descriptor_handle_table_core uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_op              (i_op),
        .i_slot            (i_slot),
        .i_target_slot     (i_target_slot),
        .i_object_handle   (i_object_handle),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_status          (o_status),
        .o_result_slot     (o_result_slot),
        .o_handle_out      (o_handle_out),
        .o_released_valid  (o_released_valid),
        .o_released_handle (o_released_handle)
    );

    // shadow of the slot table, updated once per accepted request
    bit                           shadow_used [TABLE_DEPTH];
    logic [dht_pkg::HANDLE_W-1:0] shadow_handle [TABLE_DEPTH];

    t_req pending_reqs [$];
    t_res expected_results [$];

    int items_sent = 0;     // requests accepted, driver side
    int n_results = 0;      // results taken, monitor side
    int results_seen = 0;   // registered copy of n_results for the driver
    int fail_cnt = 0;
    int cycle_cnt = 0;
    int op_tally [8];
    int st_tally [4];
    int rel_tally = 0;
    bit calm_send = 0;      // episode with no sender gaps

    // ---------------------------------------------------------------
    // table behavior
    // ---------------------------------------------------------------

    // lowest free slot, -1 when every slot is held
    function automatic int lowest_free_slot();
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (!shadow_used[i])
                return i;
        return -1;
    endfunction

    // write a handle into a slot, reporting whatever it displaced
    function automatic void store_handle(input int s, input logic [dht_pkg::HANDLE_W-1:0] h,
                                         inout t_res r);
        if (shadow_used[s]) begin
            r.rel_v = 1'b1;
            r.rel_h = shadow_handle[s];
        end
        shadow_used[s] = 1'b1;
        shadow_handle[s] = h;
    endfunction

    function automatic t_res apply_table_op(t_req q);
        t_res r;
        int   s;
        int   t;
        int   f;
        bit   src_held;
        r = '{status: dht_pkg::ST_OK, rslot: '0, hout: '0, rel_v: 1'b0, rel_h: '0};
        s = int'(q.slot);
        t = int'(q.tgt);
        src_held = (s < TABLE_DEPTH) && shadow_used[s];
        case (q.op)
            dht_pkg::OP_OPEN: begin
                f = lowest_free_slot();
                if (f < 0) begin
                    r.status = dht_pkg::ST_FULL;
                end else begin
                    store_handle(f, q.handle, r);
                    r.rslot = dht_pkg::RSLOT_W'(f);
                end
            end
            dht_pkg::OP_OPEN_AT: begin
                if (s >= TABLE_DEPTH) begin
                    r.status = dht_pkg::ST_INVAL;
                end else begin
                    store_handle(s, q.handle, r);
                    r.rslot = dht_pkg::RSLOT_W'(s);
                end
            end
            dht_pkg::OP_CLOSE: begin
                if (!src_held) begin
                    r.status = dht_pkg::ST_BADF;
                end else begin
                    r.rel_v = 1'b1;
                    r.rel_h = shadow_handle[s];
                    shadow_used[s] = 1'b0;
                    r.rslot = dht_pkg::RSLOT_W'(s);
                end
            end
            dht_pkg::OP_LOOKUP: begin
                if (!src_held) begin
                    r.status = dht_pkg::ST_BADF;
                end else begin
                    r.hout = shadow_handle[s];
                    r.rslot = dht_pkg::RSLOT_W'(s);
                end
            end
            dht_pkg::OP_DUP: begin
                f = lowest_free_slot();
                if (!src_held) begin
                    r.status = dht_pkg::ST_BADF;
                end else if (f < 0) begin
                    r.status = dht_pkg::ST_FULL;
                end else begin
                    r.hout = shadow_handle[s];
                    store_handle(f, r.hout, r);
                    r.rslot = dht_pkg::RSLOT_W'(f);
                end
            end
            dht_pkg::OP_DUP_TO: begin
                if (!src_held || t >= TABLE_DEPTH) begin
                    r.status = dht_pkg::ST_BADF;
                end else begin
                    r.hout = shadow_handle[s];
                    // copy onto itself leaves the table as it is
                    if (t != s)
                        store_handle(t, r.hout, r);
                    r.rslot = dht_pkg::RSLOT_W'(t);
                end
            end
            default: r.status = dht_pkg::ST_INVAL;
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    task automatic push_req(input logic [dht_pkg::OP_W-1:0] op, input int s, input int t,
                            input logic [dht_pkg::HANDLE_W-1:0] h, input bit drain = 0);
        t_req q;
        q.op = op;
        q.slot = dht_pkg::SLOT_W'(s);
        q.tgt = dht_pkg::SLOT_W'(t);
        q.handle = h;
        q.gap_cyc = calm_send ? 0 : $urandom_range(0, 6);
        q.drain = drain;
        pending_reqs.push_back(q);
    endtask

    // mostly in range and biased low so opens and closes meet, some out of range
    function automatic int rand_slot();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom_range(0, 7);
            9:       return $urandom_range(TABLE_DEPTH, 255);
            default: return $urandom_range(0, TABLE_DEPTH - 1);
        endcase
    endfunction

    function automatic logic [dht_pkg::HANDLE_W-1:0] rand_handle();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // clock, reset, watchdog
    // ---------------------------------------------------------------

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d sent, %0d back",
                     cycle_cnt, items_sent, n_results);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // request driver: offers queued items, predicts on acceptance
    // ---------------------------------------------------------------

    t_req cur_req;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_results.push_back(apply_table_op(cur_req));
                items_sent++;
                op_tally[cur_req.op]++;
            end
            // free to change the payload unless an offered item is still waiting
            if (!i_valid || o_ready) begin
                if (pending_reqs.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (pending_reqs[0].gap_cyc > 0) begin
                    pending_reqs[0].gap_cyc = pending_reqs[0].gap_cyc - 1;
                    i_valid <= 1'b0;
                end else if (pending_reqs[0].drain && items_sent != results_seen) begin
                    // pause until the block has handed back everything
                    i_valid <= 1'b0;
                end else begin
                    cur_req = pending_reqs.pop_front();
                    i_valid <= 1'b1;
                    i_op <= cur_req.op;
                    i_slot <= cur_req.slot;
                    i_target_slot <= cur_req.tgt;
                    i_object_handle <= cur_req.handle;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // result monitor: compares in order and paces i_ready
    // ---------------------------------------------------------------

    task automatic check_field(input string name, input logic [dht_pkg::HANDLE_W-1:0] want,
                               input logic [dht_pkg::HANDLE_W-1:0] got);
        if (want !== got) begin
            $error("result %0d %s: expected 0x%0h, got 0x%0h", n_results, name, want, got);
            fail_cnt++;
        end
    endtask

    int  stall_left = 0;
    bit  long_hold_done = 0;

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && i_ready) begin
                n_results++;
                results_seen <= n_results;
                st_tally[o_status]++;
                if (o_released_valid === 1'b1)
                    rel_tally++;
                if (expected_results.size() == 0) begin
                    $error("result %0d arrived with no request outstanding", n_results);
                    fail_cnt++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", dht_pkg::HANDLE_W'(want.status),
                                dht_pkg::HANDLE_W'(o_status));
                    check_field("result_slot", dht_pkg::HANDLE_W'(want.rslot),
                                dht_pkg::HANDLE_W'(o_result_slot));
                    check_field("handle_out", want.hout, o_handle_out);
                    check_field("released_valid", dht_pkg::HANDLE_W'(want.rel_v),
                                dht_pkg::HANDLE_W'(o_released_valid));
                    check_field("released_handle", want.rel_h, o_released_handle);
                end
                // one long back-pressure stretch so the block fills and stalls
                if (n_results == LONG_HOLD_AT && !long_hold_done) begin
                    long_hold_done = 1;
                    stall_left = LONG_HOLD_CYC;
                end else if ((n_results / 40) % 4 == 3) begin
                    stall_left = 0;
                end else begin
                    stall_left = $urandom_range(0, 6);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus and end of run
    // ---------------------------------------------------------------

    initial begin
        int n_rand;
        int episode;
        int len;
        int pick;
        bit drain_first;

        foreach (shadow_used[i]) shadow_used[i] = 1'b0;
        foreach (op_tally[i]) op_tally[i] = 0;
        foreach (st_tally[i]) st_tally[i] = 0;

        // directed: empty-table errors, unknown ops, field extremes, releases
        push_req(dht_pkg::OP_LOOKUP, 0, 0, '0);
        push_req(dht_pkg::OP_CLOSE, 0, 0, '0);
        push_req(dht_pkg::OP_DUP, 0, 0, '0);
        push_req(dht_pkg::OP_DUP_TO, 0, 1, '0);
        push_req(OP_UNDEF_A, 255, 255, '1);
        push_req(OP_UNDEF_B, 0, 0, '0);
        push_req(dht_pkg::OP_OPEN, 0, 0, '0);
        push_req(dht_pkg::OP_OPEN, 255, 255, '1);
        push_req(dht_pkg::OP_OPEN_AT, TABLE_DEPTH - 1, 0, 32'ha5a5_a5a5);
        push_req(dht_pkg::OP_OPEN_AT, TABLE_DEPTH, 0, 32'h1234_5678);
        push_req(dht_pkg::OP_OPEN_AT, 255, 0, 32'h8765_4321);
        // open-at over a held slot gives back the old handle
        push_req(dht_pkg::OP_OPEN_AT, 1, 0, 32'h5a5a_5a5a);
        push_req(dht_pkg::OP_LOOKUP, TABLE_DEPTH - 1, 0, '0);
        push_req(dht_pkg::OP_LOOKUP, 255, 0, '0);
        push_req(dht_pkg::OP_CLOSE, 200, 0, '0);
        push_req(dht_pkg::OP_DUP, 1, 0, '0);
        // copy onto itself: ok, nothing released
        push_req(dht_pkg::OP_DUP_TO, 1, 1, '0);
        push_req(dht_pkg::OP_DUP_TO, 0, 10, '0);
        push_req(dht_pkg::OP_DUP_TO, 1, TABLE_DEPTH - 1, '0);
        push_req(dht_pkg::OP_DUP_TO, 1, TABLE_DEPTH, '0);
        push_req(dht_pkg::OP_DUP_TO, 200, 5, '0);
        push_req(dht_pkg::OP_DUP_TO, 40, 3, '0);
        push_req(dht_pkg::OP_CLOSE, 2, 0, '0);
        push_req(dht_pkg::OP_LOOKUP, 2, 0, '0);

        // random episodes; the first fills the table past full
        n_rand = 0;
        episode = 0;
        while (n_rand < RANDOM_ITEMS) begin
            calm_send = ($urandom_range(0, 3) == 0);
            drain_first = (episode == 1) || ($urandom_range(0, 4) == 0);
            if (episode == 0 || $urandom_range(0, 3) == 0) begin
                // fill burst of opens and dups, then free some slots again
                len = $urandom_range(66, 72);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 3) == 0)
                        push_req(dht_pkg::OP_DUP, $urandom_range(0, TABLE_DEPTH - 1),
                                 $urandom, rand_handle(), drain_first && i == 0);
                    else
                        push_req(dht_pkg::OP_OPEN, $urandom, $urandom, rand_handle(),
                                 drain_first && i == 0);
                end
                len += $urandom_range(2, 5);
                for (int i = 0; i < 3; i++)
                    push_req(dht_pkg::OP_DUP_TO, $urandom_range(0, TABLE_DEPTH - 1),
                             $urandom_range(0, TABLE_DEPTH - 1), $urandom);
                for (int i = 0; i < len - 69; i++)
                    push_req(dht_pkg::OP_CLOSE, $urandom_range(0, TABLE_DEPTH - 1),
                             $urandom, '0);
                len = len + 3;
                pick = $urandom_range(10, 25);
                for (int i = 0; i < pick; i++)
                    push_req(dht_pkg::OP_CLOSE, rand_slot(), $urandom, $urandom);
                len += pick;
            end else begin
                // mixed traffic, weighted so the table stays partly full
                len = $urandom_range(20, 60);
                for (int i = 0; i < len; i++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 20)
                        push_req(dht_pkg::OP_OPEN, $urandom, $urandom, rand_handle(),
                                 drain_first && i == 0);
                    else if (pick < 35)
                        push_req(dht_pkg::OP_OPEN_AT, rand_slot(), $urandom, rand_handle(),
                                 drain_first && i == 0);
                    else if (pick < 58)
                        push_req(dht_pkg::OP_CLOSE, rand_slot(), $urandom, $urandom,
                                 drain_first && i == 0);
                    else if (pick < 73)
                        push_req(dht_pkg::OP_LOOKUP, rand_slot(), $urandom, $urandom,
                                 drain_first && i == 0);
                    else if (pick < 84)
                        push_req(dht_pkg::OP_DUP, rand_slot(), $urandom, $urandom,
                                 drain_first && i == 0);
                    else if (pick < 97)
                        push_req(dht_pkg::OP_DUP_TO, rand_slot(), rand_slot(), $urandom,
                                 drain_first && i == 0);
                    else
                        push_req(($urandom_range(0, 1) != 0) ? OP_UNDEF_A : OP_UNDEF_B,
                                 $urandom, $urandom, $urandom, drain_first && i == 0);
                end
            end
            n_rand += len;
            episode++;
        end

        // sample on the falling edge so every driver update has landed
        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || i_valid || results_seen != items_sent);
        repeat (10) @(posedge i_clk);

        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            fail_cnt++;
        end

        $write("covered %0d requests: open %0d, open_at %0d, close %0d, lookup %0d, ",
               items_sent, op_tally[dht_pkg::OP_OPEN], op_tally[dht_pkg::OP_OPEN_AT],
               op_tally[dht_pkg::OP_CLOSE], op_tally[dht_pkg::OP_LOOKUP]);
        $display("dup %0d, dup_to %0d, unknown %0d",
                 op_tally[dht_pkg::OP_DUP], op_tally[dht_pkg::OP_DUP_TO],
                 op_tally[OP_UNDEF_A] + op_tally[OP_UNDEF_B]);
        $write("results: ok %0d, invalid %0d, bad descriptor %0d, ",
               st_tally[dht_pkg::ST_OK], st_tally[dht_pkg::ST_INVAL],
               st_tally[dht_pkg::ST_BADF]);
        $display("table full %0d, released %0d", st_tally[dht_pkg::ST_FULL], rel_tally);
        if (fail_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
